// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MACT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MACT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MACT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MACT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/mact_pkg.sv =====
// types, codes and helpers of the moving average crossover trader
// no dependencies
package mact_pkg;

  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] price;
    logic [11:0] year;
    logic [3:0]  month;
  } in_t;

  typedef struct packed {
    logic [47:0] portfolio_value;
    logic [1:0]  action;
    logic [15:0] trade_total;
    logic [47:0] invested_total;
    logic        holding;
    logic        averages_ready;
  } out_t;

  // action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_BUY  = 2'd1;
  localparam logic [1:0] ACT_SELL = 2'd2;

  // relation of short average to long average
  localparam logic [1:0] REL_EQUAL   = 2'd0;
  localparam logic [1:0] REL_LESS    = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SHORT_WINDOW = 3'd0;
  localparam logic [2:0] CFG_LONG_WINDOW  = 3'd1;
  localparam logic [2:0] CFG_MONTHLY_CAP  = 3'd2;
  localparam logic [2:0] CFG_START_YEAR   = 3'd3;
  localparam logic [2:0] CFG_END_YEAR     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_CMP0,
    ST_CMP1,
    ST_CMP2,
    ST_CMP3,
    ST_CMP4,
    ST_DECIDE,
    ST_DIV,
    ST_VAL0,
    ST_VAL1,
    ST_VAL2,
    ST_DONE
  } state_t;

  // saturating 48 bit add
  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MASK48 : s[47:0];
  endfunction

endpackage

// ===== design/mact_div.sv =====
// bit-serial divider: floor(dividend * 2^32 / divisor), saturating to 64 bits
// depends on mact_pkg
module mact_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import mact_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [63:0] qsh;
  logic [31:0] dvs;
  logic [32:0] rem_shift;
  logic        qbit;

  // one quotient bit per cycle
  assign rem_shift = {rem[31:0], qsh[63]};
  assign qbit      = rem_shift >= {1'b0, dvs};
  assign quotient  = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // zero price or integer part too large saturates at once
        if (divisor == 32'd0 || {16'd0, dividend[47:32]} >= divisor) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      cnt <= 6'd0;
      rem <= {17'd0, dividend[47:32]};
      if (divisor == 32'd0 || {16'd0, dividend[47:32]} >= divisor) begin
        qsh <= '1;
      end else begin
        qsh <= {dividend[31:0], 32'd0};
      end
    end else if (busy) begin
      rem <= qbit ? (rem_shift - {1'b0, dvs}) : rem_shift;
      qsh <= {qsh[62:0], qbit};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

// ===== design/moving_average_crossover_trader.sv =====
// moving average crossover trader: tick sequencer, price ring, shared multiplier
// depends on mact_pkg, mact_div and assert_macros.svh
//
// Usage
//   in channel (in_valid/in_ready/in_data): one price tick per transaction.
//   Ticks whose year is outside [start_year, end_year] are taken while idle
//   and give no result.
//   out channel (out_valid/out_ready/out_data): one result per in-range tick.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while the block is idle. Unknown indexes are ignored.
// An in-range tick runs a ring write, a sum pass over N entries, where N is the
//   larger clamped window held in the ring (up to MAX_WINDOW), compare and
//   decide, the bit-serial divider on a buy, valuation, done. The ring sum pass,
//   one ring read per cycle, sets the rate; in_ready is high only when idle.
// A finished result sits in the output register; the next tick is accepted
//   while it waits, and that tick's result waits for the register to free.
// Reset (synchronous, rst) clears the running counters, sums and cash and
//   restores the register defaults; the ring needs no clearing.
module moving_average_crossover_trader #(
  parameter int MAX_WINDOW = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mact_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mact_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import mact_pkg::*;

  `include "assert_macros.svh"

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int XW   = (CW > 9) ? CW : 9;
  localparam int SUMW = 32 + CW;
  localparam int CMPW = SUMW + XW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);
  localparam logic [XW-1:0] MAXW_X    = XW'(MAX_WINDOW);

  // configuration registers
  logic [8:0]  short_window;
  logic [8:0]  long_window;
  logic [31:0] monthly_capital;
  logic [11:0] start_year;
  logic [11:0] end_year;

  // state
  state_t          state, state_next;
  logic [31:0]     ring [MAX_WINDOW];
  logic [AW-1:0]   ring_head;
  logic [CW-1:0]   fill_count;
  logic [SUMW-1:0] short_sum;
  logic [SUMW-1:0] long_sum;
  logic [47:0]     cash_held;
  logic [63:0]     shares_held;
  logic [47:0]     invested_sum;
  logic [15:0]     trade_count;
  logic            in_position;
  logic [1:0]      previous_relation;
  logic [15:0]     last_period;
  logic            last_period_valid;

  // per tick work registers
  logic [31:0]     price;
  logic [15:0]     period;
  logic [XW-1:0]   rd_i;
  logic [AW-1:0]   rp;
  logic            pend;
  logic [XW-1:0]   pend_i;
  logic [31:0]     rd_data;
  logic [63:0]     prod;
  logic [63:0]     hi_r;
  logic [CMPW-1:0] lhs;
  logic [CMPW-1:0] rhs;
  logic            sell_r;
  logic [1:0]      action;
  logic [47:0]     value;

  // control
  logic        mem_rd;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_q;

  // clamped windows and counts
  logic [XW-1:0] sw_x, lw_x, sw_c, lw_c, fill_x, n_s, n_l, n_max;
  logic          avg_ready;
  logic          year_ok;
  logic [1:0]    rel;
  logic          buy, sell;
  logic [47:0]     stp;

  assign sw_x   = XW'(short_window);
  assign lw_x   = XW'(long_window);
  assign sw_c   = (sw_x == '0) ? XW'(1) : ((sw_x > MAXW_X) ? MAXW_X : sw_x);
  assign lw_c   = (lw_x == '0) ? XW'(1) : ((lw_x > MAXW_X) ? MAXW_X : lw_x);
  assign fill_x = XW'(fill_count);
  assign n_s    = (sw_c < fill_x) ? sw_c : fill_x;
  assign n_l    = (lw_c < fill_x) ? lw_c : fill_x;
  assign n_max  = (n_s > n_l) ? n_s : n_l;
  assign avg_ready = (fill_x >= sw_c) && (fill_x >= lw_c);
  assign year_ok   = (in_data.year >= start_year) && (in_data.year <= end_year);

  // crossover decision
  assign rel  = (lhs > rhs) ? REL_GREATER : ((lhs < rhs) ? REL_LESS : REL_EQUAL);
  assign buy  = (previous_relation != REL_GREATER) && (rel == REL_GREATER) && !in_position;
  assign sell = (previous_relation != REL_LESS) && (rel == REL_LESS) && in_position;

  // shares times price, truncated and saturated
  assign stp = (hi_r[63:48] != 16'd0) ? MASK48 : add48(hi_r[47:0], {16'd0, prod[63:32]});

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && year_ok) state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_SUM;
      ST_SUM: begin
        if (rd_i == n_max && !pend) state_next = avg_ready ? ST_CMP0 : ST_VAL0;
      end
      ST_CMP0:   state_next = ST_CMP1;
      ST_CMP1:   state_next = ST_CMP2;
      ST_CMP2:   state_next = ST_CMP3;
      ST_CMP3:   state_next = ST_CMP4;
      ST_CMP4:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = buy ? ST_DIV : ST_VAL0;
      ST_DIV:    if (div_done) state_next = ST_VAL0;
      ST_VAL0:   state_next = ST_VAL1;
      ST_VAL1:   state_next = ST_VAL2;
      ST_VAL2:   state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs and shared multiplier operands
  always_comb begin
    in_ready  = 1'b0;
    mem_rd    = 1'b0;
    div_start = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SUM:    mem_rd = (rd_i < n_max);
      ST_CMP0: begin
        mul_a = short_sum[31:0];
        mul_b = 32'(lw_c);
      end
      ST_CMP1: begin
        mul_a = 32'(short_sum[SUMW-1:32]);
        mul_b = 32'(lw_c);
      end
      ST_CMP2: begin
        mul_a = long_sum[31:0];
        mul_b = 32'(sw_c);
      end
      ST_CMP3: begin
        mul_a = 32'(long_sum[SUMW-1:32]);
        mul_b = 32'(sw_c);
      end
      ST_DECIDE: div_start = buy;
      ST_VAL0: begin
        mul_a = shares_held[63:32];
        mul_b = price;
      end
      ST_VAL1: begin
        mul_a = shares_held[31:0];
        mul_b = price;
      end
      default: ;
    endcase
  end

  // price ring
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) ring[ring_head] <= price;
    if (mem_rd) rd_data <= ring[rp];
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  mact_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cash_held),
    .divisor  (price),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      short_window    <= 9'd50;
      long_window     <= 9'd200;
      monthly_capital <= 32'd65536000;
      start_year      <= 12'd0;
      end_year        <= 12'd4095;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHORT_WINDOW: short_window    <= cfg_data[8:0];
        CFG_LONG_WINDOW:  long_window     <= cfg_data[8:0];
        CFG_MONTHLY_CAP:  monthly_capital <= cfg_data;
        CFG_START_YEAR:   start_year      <= cfg_data[11:0];
        CFG_END_YEAR:     end_year        <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      ring_head         <= '0;
      fill_count        <= '0;
      cash_held         <= '0;
      shares_held       <= '0;
      invested_sum      <= '0;
      trade_count       <= '0;
      in_position       <= 1'b0;
      previous_relation <= REL_EQUAL;
      last_period_valid <= 1'b0;
      pend              <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      // result register valid
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_WRITE: begin
          ring_head <= (ring_head == LAST_ADDR) ? '0 : ring_head + AW'(1);
          if (fill_count < CW'(MAX_WINDOW)) fill_count <= fill_count + CW'(1);
          if (!last_period_valid || last_period != period) begin
            cash_held         <= add48(cash_held, {16'd0, monthly_capital});
            last_period_valid <= 1'b1;
          end
        end
        ST_SUM:    pend <= mem_rd;
        ST_DECIDE: begin
          previous_relation <= rel;
          if (buy || sell) begin
            if (trade_count != 16'hFFFF) trade_count <= trade_count + 16'd1;
          end
          if (buy) begin
            invested_sum <= add48(invested_sum, cash_held);
            cash_held    <= '0;
            in_position  <= 1'b1;
          end else if (sell) begin
            in_position <= 1'b0;
          end
        end
        ST_DIV:    if (div_done) shares_held <= div_q;
        ST_VAL2: begin
          if (sell_r) begin
            cash_held   <= add48(cash_held, stp);
            shares_held <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per tick datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        price  <= in_data.price;
        period <= {in_data.year, in_data.month};
      end
      ST_WRITE: begin
        last_period <= period;
        action      <= ACT_NONE;
        sell_r      <= 1'b0;
        short_sum   <= '0;
        long_sum    <= '0;
        rd_i        <= '0;
        rp          <= ring_head;
      end
      ST_SUM: begin
        // newest first, one ring read per cycle, data back in the next cycle
        if (mem_rd) begin
          rp     <= (rp == '0) ? LAST_ADDR : rp - AW'(1);
          rd_i   <= rd_i + XW'(1);
          pend_i <= rd_i;
        end
        if (pend) begin
          if (pend_i < n_s) short_sum <= short_sum + SUMW'(rd_data);
          if (pend_i < n_l) long_sum  <= long_sum + SUMW'(rd_data);
        end
      end
      ST_CMP1:   lhs <= CMPW'(prod);
      ST_CMP2:   lhs <= lhs + (CMPW'(prod) << 32);
      ST_CMP3:   rhs <= CMPW'(prod);
      ST_CMP4:   rhs <= rhs + (CMPW'(prod) << 32);
      ST_DECIDE: begin
        action <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
        sell_r <= sell;
      end
      ST_VAL1:   hi_r <= prod;
      ST_VAL2:   value <= add48(cash_held, stp);
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.portfolio_value <= value;
          out_data.action          <= action;
          out_data.trade_total     <= trade_count;
          out_data.invested_total  <= invested_sum;
          out_data.holding         <= in_position;
          out_data.averages_ready  <= avg_ready;
        end
      end
      default: ;
    endcase
  end

  // checks
  `MACT_ASSERT_IMP(a_buy_holds, clk, rst, out_valid && out_data.action == ACT_BUY, out_data.holding, "buy result without position")
  `MACT_ASSERT_IMP(a_div_in_wait, clk, rst, div_done, state == ST_DIV, "divider finished outside wait state")
  `MACT_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill_count <= CW'(MAX_WINDOW), "fill count beyond ring depth")
  `MACT_ASSERT_NXT(a_decide_buy, clk, rst, state == ST_DECIDE && buy, state == ST_DIV && in_position, "buy did not start division")

endmodule

// ===== verif/moving_average_crossover_trader_tb.sv =====
// self-checking testbench for the moving average crossover trader
// depends on mact_pkg and the moving_average_crossover_trader rtl
// a predictor built into the bench checks every result transaction in order
module moving_average_crossover_trader_tb;
  import mact_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int SETTLE_CYC   = 400;
  localparam int WATCHDOG_CYC = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_SHORT_WINDOW;
  logic [31:0] cfg_data = '0;

  // trader model state
  logic [31:0] tick_ring [RING_DEPTH];
  logic [7:0]  tick_head;
  int unsigned tick_fill;
  logic [47:0] cash_bal;
  logic [63:0] share_bal;
  logic [47:0] spent_bal;
  logic [15:0] trade_cnt;
  logic        long_pos;
  logic [1:0]  prev_rel;
  logic        period_seen;
  logic [15:0] prev_period;
  logic [8:0]  short_len, long_len;
  logic [31:0] month_cash;
  logic [11:0] first_year, last_year;

  out_t        pending_results[$];
  int          fail_cnt = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          quiet_cyc = 0;

  // stimulus walk state
  logic [31:0] walk_price;
  logic [11:0] walk_year;
  logic [3:0]  walk_month;

  moving_average_crossover_trader u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic int unsigned clamp_len(logic [8:0] w);
    if (w == 0) return 1;
    if (w > RING_DEPTH) return RING_DEPTH;
    return w;
  endfunction

  function automatic logic [63:0] newest_sum(int unsigned n);
    logic [63:0] s;
    logic [7:0]  idx;
    s = 0;
    if (n > tick_fill) n = tick_fill;
    for (int i = 0; i < n; i++) begin
      idx = tick_head - 8'd1 - 8'(i);
      s += tick_ring[idx];
    end
    return s;
  endfunction

  // floor(shares * price / 2^32), saturated to 48 bits
  function automatic logic [47:0] holding_worth(logic [63:0] sh, logic [31:0] pr);
    logic [63:0] hi, lo;
    hi = {32'd0, sh[63:32]} * {32'd0, pr};
    lo = ({32'd0, sh[31:0]} * {32'd0, pr}) >> 32;
    if (hi > 64'hFFFF_FFFF_FFFF) return 48'hFFFF_FFFF_FFFF;
    return sat_add48(hi[47:0], lo[47:0]);
  endfunction

  // floor(cash * 2^32 / price), saturated to 64 bits
  function automatic logic [63:0] shares_bought(logic [47:0] cash, logic [31:0] pr);
    logic [63:0] qi, rem, qf;
    if (pr == 0) return '1;
    qi = {16'd0, cash} / pr;
    if (qi > 64'hFFFF_FFFF) return '1;
    rem = {16'd0, cash} % pr;
    qf = (rem << 32) / pr;
    return (qi << 32) + qf;
  endfunction

  function automatic void model_reset();
    tick_head = 0; tick_fill = 0; cash_bal = 0; share_bal = 0; spent_bal = 0;
    trade_cnt = 0; long_pos = 0; prev_rel = REL_EQUAL; period_seen = 0;
    prev_period = 0; short_len = 50; long_len = 200; month_cash = 32'd65536000;
    first_year = 0; last_year = 12'd4095;
  endfunction

  // work out the result of one accepted tick
  function automatic void predict_tick(in_t t);
    int unsigned sw, lw;
    logic [63:0] ssum, lsum, lhs, rhs;
    logic [1:0]  rel;
    logic        full;
    out_t        r;
    if (t.year < first_year || t.year > last_year) return;
    sw = clamp_len(short_len);
    lw = clamp_len(long_len);
    r = '0;
    r.action = ACT_NONE;
    tick_ring[tick_head] = t.price;
    tick_head++;
    if (tick_fill < RING_DEPTH) tick_fill++;
    ssum = newest_sum(sw);
    lsum = newest_sum(lw);
    if (!period_seen || prev_period != {t.year, t.month}) begin
      cash_bal = sat_add48(cash_bal, {16'd0, month_cash});
      prev_period = {t.year, t.month};
      period_seen = 1;
    end
    full = tick_fill >= sw && tick_fill >= lw;
    if (full) begin
      lhs = ssum * lw;
      rhs = lsum * sw;
      rel = lhs > rhs ? REL_GREATER : (lhs < rhs ? REL_LESS : REL_EQUAL);
      if (prev_rel != REL_GREATER && rel == REL_GREATER && !long_pos) begin
        share_bal = shares_bought(cash_bal, t.price);
        spent_bal = sat_add48(spent_bal, cash_bal);
        cash_bal = 0;
        long_pos = 1;
        if (trade_cnt != 16'hFFFF) trade_cnt++;
        r.action = ACT_BUY;
      end else if (prev_rel != REL_LESS && rel == REL_LESS && long_pos) begin
        cash_bal = sat_add48(cash_bal, holding_worth(share_bal, t.price));
        share_bal = 0;
        long_pos = 0;
        if (trade_cnt != 16'hFFFF) trade_cnt++;
        r.action = ACT_SELL;
      end
      prev_rel = rel;
    end
    r.portfolio_value = sat_add48(cash_bal, holding_worth(share_bal, t.price));
    r.trade_total = trade_cnt;
    r.invested_total = spent_bal;
    r.holding = long_pos;
    r.averages_ready = full;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  // result checker
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.portfolio_value !== exp_r.portfolio_value) begin
          $error("portfolio_value exp %0h got %0h", exp_r.portfolio_value,
                 out_data.portfolio_value);
          fail_cnt++;
        end
        if (out_data.action !== exp_r.action) begin
          $error("action exp %0d got %0d", exp_r.action, out_data.action);
          fail_cnt++;
        end
        if (out_data.trade_total !== exp_r.trade_total) begin
          $error("trade_total exp %0d got %0d", exp_r.trade_total, out_data.trade_total);
          fail_cnt++;
        end
        if (out_data.invested_total !== exp_r.invested_total) begin
          $error("invested_total exp %0h got %0h", exp_r.invested_total,
                 out_data.invested_total);
          fail_cnt++;
        end
        if (out_data.holding !== exp_r.holding) begin
          $error("holding exp %0d got %0d", exp_r.holding, out_data.holding);
          fail_cnt++;
        end
        if (out_data.averages_ready !== exp_r.averages_ready) begin
          $error("averages_ready exp %0d got %0d", exp_r.averages_ready,
                 out_data.averages_ready);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WATCHDOG_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one tick; valid stays up into the next call unless a gap is drawn
  task automatic send_tick(logic [31:0] price, logic [11:0] year, logic [3:0] month);
    in_t t;
    t = '{price: price, year: year, month: month};
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    predict_tick(t);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SHORT_WINDOW: short_len = val[8:0];
      CFG_LONG_WINDOW:  long_len = val[8:0];
      CFG_MONTHLY_CAP:  month_cash = val;
      CFG_START_YEAR:   first_year = val[11:0];
      CFG_END_YEAR:     last_year = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [8:0] sw, logic [8:0] lw, logic [31:0] cap,
                            logic [11:0] y0, logic [11:0] y1);
    wait_results();
    write_reg(CFG_SHORT_WINDOW, 32'(sw));
    write_reg(CFG_LONG_WINDOW, 32'(lw));
    write_reg(CFG_MONTHLY_CAP, cap);
    write_reg(CFG_START_YEAR, 32'(y0));
    write_reg(CFG_END_YEAR, 32'(y1));
    cfg_valid <= 1'b0;
  endtask

  // next tick of a trending walk; months advance every few ticks
  task automatic walk_tick(bit up);
    logic [31:0] step;
    step = $urandom_range(1, 40) << 14;
    if (up) walk_price = (walk_price > 32'hF000_0000) ? walk_price : walk_price + step;
    else walk_price = (walk_price <= step + 32'h1_0000) ? walk_price : walk_price - step;
    if ($urandom_range(3) == 0) begin
      if (walk_month >= 12) begin
        walk_month = 4'd1;
        walk_year++;
      end else walk_month++;
    end
    send_tick(walk_price, walk_year, walk_month);
  endtask

  // a few ticks with the reset defaults
  task automatic test_reset_defaults();
    send_tick(32'h0001_0000, 12'd0, 4'd1);
    send_tick(32'hFFFF_FFFF, 12'd4095, 4'd12);
    send_tick(32'h0000_0001, 12'd4095, 4'd12);
  endtask

  // small windows: golden cross, death cross, zero price, odd months, max price
  task automatic test_crosses();
    set_config(9'd2, 9'd4, 32'h0064_0000, 12'd0, 12'd4095);
    send_tick(32'h000A_0000, 12'd2000, 4'd0);
    send_tick(32'h000A_0000, 12'd2000, 4'd13);
    send_tick(32'h000A_0000, 12'd2000, 4'd15);
    send_tick(32'h000A_0000, 12'd2000, 4'd15);
    send_tick(32'h0014_0000, 12'd2000, 4'd15);
    send_tick(32'h0028_0000, 12'd2001, 4'd1);
    send_tick(32'h0001_0000, 12'd2001, 4'd2);
    send_tick(32'h0000_8000, 12'd2001, 4'd3);
    send_tick(32'hFFFF_FFFF, 12'd2001, 4'd4);
    send_tick(32'hFFFF_FFFF, 12'd2001, 4'd5);
    send_tick(32'h0000_0001, 12'd2001, 4'd6);
    send_tick(32'h0000_0000, 12'd2001, 4'd6);
    send_tick(32'h0000_0000, 12'd2001, 4'd7);
    send_tick(32'hFFFF_FFFF, 12'd2001, 4'd8);
  endtask

  // year window, including an empty one
  task automatic test_year_filter();
    set_config(9'd1, 9'd3, 32'hFFFF_FFFF, 12'd100, 12'd200);
    send_tick(32'h0002_0000, 12'd99, 4'd1);
    send_tick(32'h0002_0000, 12'd100, 4'd1);
    send_tick(32'h0002_0000, 12'd201, 4'd1);
    send_tick(32'h0003_0000, 12'd200, 4'd2);
    send_tick(32'h0005_0000, 12'd150, 4'd3);
    set_config(9'd1, 9'd3, 32'd0, 12'd4095, 12'd0);
    send_tick(32'h0002_0000, 12'd0, 4'd1);
    send_tick(32'h0002_0000, 12'd4095, 4'd1);
  endtask

  // window extremes: zero, full ring and above the ring size
  task automatic test_window_extremes();
    set_config(9'd0, 9'd511, 32'h0100_0000, 12'd0, 12'd4095);
    walk_price = 32'h0064_0000; walk_year = 12'd1000; walk_month = 4'd1;
    for (int i = 0; i < 270; i++) walk_tick((i / 40) % 2 == 0);
    set_config(9'd256, 9'd1, 32'h0010_0000, 12'd0, 12'd4095);
    for (int i = 0; i < 20; i++) walk_tick(i < 10);
  endtask

  // random trends with noise under one idling pattern
  task automatic test_random_phase(int idle_pct, int stall_pct, int n);
    bit up;
    int seg;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    set_config(9'($urandom_range(0, 8)), 9'($urandom_range(2, 16)), $urandom,
               12'($urandom_range(0, 1500)), 12'($urandom_range(2500, 4095)));
    walk_price = $urandom_range(32'h0001_0000, 32'h4000_0000);
    walk_year = 12'($urandom_range(1500, 2500));
    walk_month = 4'd1;
    up = 1;
    seg = 0;
    for (int i = 0; i < n; i++) begin
      if (seg == 0) begin
        up = !up;
        seg = $urandom_range(3, 20);
      end
      seg--;
      if ($urandom_range(9) == 0)
        send_tick($urandom, 12'($urandom), 4'($urandom));
      else
        walk_tick(up);
    end
  endtask

  // sender waits for every result before each tick
  task automatic test_drain_pause();
    send_idle = 0;
    recv_stall = 47;
    set_config(9'd3, 9'd5, 32'h0020_0000, 12'd0, 12'd4095);
    for (int i = 0; i < 12; i++) begin
      wait_results();
      walk_tick(i < 6);
    end
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_crosses();
    test_year_filter();
    test_window_extremes();
    test_random_phase(0, 0, 70);
    test_random_phase(47, 0, 70);
    test_random_phase(0, 47, 70);
    test_random_phase(6, 6, 70);
    test_drain_pause();
    wait_results();
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
